### rtl/eam_pkg.sv
`default_nettype none

package eam_pkg;

  // Port widths
  localparam int ANG_W = 16;
  localparam int OUT_W = 16;

  // Folded angle: 0 .. one quarter turn inclusive
  localparam int QTR_W = 14;
  localparam int RED_W = QTR_W + 1;
  localparam logic [RED_W-1:0] QUARTER = RED_W'(16384);

  // Coarse / fine split of the folded angle
  localparam int LO_W     = 7;
  localparam int COARSE_N = 129;
  localparam int FINE_N   = 128;

  // Table precision: unsigned, 52 fraction bits, 1.0 representable
  localparam int TBL_FRAC = 52;
  localparam int TBL_W    = TBL_FRAC + 1;
  localparam int SPLIT    = 26;
  localparam int TOP_W    = TBL_W - SPLIT;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;

  localparam real FULL_TURN = 65536.0;
  localparam real PI        = 3.14159265358979323846;
  localparam real TBL_SCALE = 4503599627370496.0;

  typedef logic [TBL_W-1:0] coarse_tbl_t [COARSE_N];
  typedef logic [TBL_W-1:0] fine_tbl_t [FINE_N];

  function automatic logic [TBL_W-1:0] to_tbl(real x);
    longint v;
    v = longint'(x * TBL_SCALE);
    return TBL_W'(v);
  endfunction

  // sin/cos at multiples of 128 angle units
  function automatic coarse_tbl_t build_coarse(bit use_cos);
    coarse_tbl_t t;
    real ang;
    for (int i = 0; i < COARSE_N; i++) begin
      ang  = 2.0 * PI * real'(i * (1 << LO_W)) / FULL_TURN;
      t[i] = use_cos ? to_tbl($cos(ang)) : to_tbl($sin(ang));
    end
    return t;
  endfunction

  // sin/cos at 0 .. 127 angle units
  function automatic fine_tbl_t build_fine(bit use_cos);
    fine_tbl_t t;
    real ang;
    for (int i = 0; i < FINE_N; i++) begin
      ang  = 2.0 * PI * real'(i) / FULL_TURN;
      t[i] = use_cos ? to_tbl($cos(ang)) : to_tbl($sin(ang));
    end
    return t;
  endfunction

  localparam coarse_tbl_t COARSE_SIN = build_coarse(1'b0);
  localparam coarse_tbl_t COARSE_COS = build_coarse(1'b1);
  localparam fine_tbl_t   FINE_SIN   = build_fine(1'b0);
  localparam fine_tbl_t   FINE_COS   = build_fine(1'b1);

  // One sine argument folded into the first quadrant
  typedef struct packed {
    logic [RED_W-1:0] r;
    logic             neg;
  } arg_t;

  // Classified request: six sine arguments
  typedef struct packed {
    arg_t sp;
    arg_t cp;
    arg_t sh;
    arg_t ch;
    arg_t sb;
    arg_t cb;
  } item_t;

endpackage

`default_nettype wire

### rtl/eam_front.sv
`default_nettype none

module eam_front import eam_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ANG_W-1:0] pitch,
  input  logic [ANG_W-1:0] heading,
  input  logic [ANG_W-1:0] bank,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output item_t            item
);

  logic vld;
  logic accept;

  // Fold a binary angle into 0..quarter plus a sign
  function automatic arg_t fold(logic [ANG_W-1:0] a);
    arg_t             f;
    logic [QTR_W-1:0] low;
    low   = a[QTR_W-1:0];
    f.neg = a[ANG_W-1];
    f.r   = a[QTR_W] ? (QUARTER - {1'b0, low}) : {1'b0, low};
    return f;
  endfunction

  // Cosine is sine a quarter turn later
  function automatic arg_t fold_cos(logic [ANG_W-1:0] a);
    return fold(a + ANG_W'(QUARTER));
  endfunction

  assign busy   = vld & q_full;
  assign accept = start & ~busy;
  assign push   = vld & ~q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= accept | busy;
    end
  end

  // Request register, held while the queue is full
  always_ff @(posedge clk) begin
    if (accept) begin
      item.sp <= fold(pitch);
      item.cp <= fold_cos(pitch);
      item.sh <= fold(heading);
      item.ch <= fold_cos(heading);
      item.sb <= fold(bank);
      item.cb <= fold_cos(bank);
    end
  end

endmodule

`default_nettype wire

### rtl/eam_fifo.sv
`default_nettype none

module eam_fifo import eam_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wr_data,
  output logic  full,
  output logic  pop,
  output item_t rd_data
);

  item_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W + 1)'(FIFO_DEPTH));
  // back end never stalls: drain whenever something is queued
  assign pop     = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/eam_sine.sv
`default_nettype none

module eam_sine import eam_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  arg_t                        arg,
  output logic signed [FRAC_BITS+1:0] val
);

  localparam int W      = FRAC_BITS + 2;
  localparam int PROD_W = 2 * TBL_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RSH    = 2 * TBL_FRAC - FRAC_BITS;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (RSH - 1);

  logic [RED_W-LO_W-1:0] hi;
  logic [LO_W-1:0]       lo;

  // stage 1: table values
  logic [TBL_W-1:0] sa1, ca1, sb1, cb1;
  logic             neg1;
  // stage 2: partial products, [0] = sa*cb, [1] = ca*sb
  logic [2*TOP_W-1:0]     pp_hh [2];
  logic [TOP_W+SPLIT-1:0] pp_hl [2];
  logic [TOP_W+SPLIT-1:0] pp_lh [2];
  logic [2*SPLIT-1:0]     pp_ll [2];
  logic                   neg2;
  // stage 3: full products
  logic [PROD_W-1:0] prod [2];
  logic              neg3;

  logic [SUM_W-1:0]     total;
  logic [FRAC_BITS:0]   mag;
  logic signed [W-1:0]  sval;

  assign hi = arg.r[RED_W-1:LO_W];
  assign lo = arg.r[LO_W-1:0];

  function automatic logic [PROD_W-1:0] combine(
    logic [2*TOP_W-1:0]     hh,
    logic [TOP_W+SPLIT-1:0] hl,
    logic [TOP_W+SPLIT-1:0] lh,
    logic [2*SPLIT-1:0]     ll
  );
    return (PROD_W'(hh) << (2 * SPLIT)) + ((PROD_W'(hl) + PROD_W'(lh)) << SPLIT)
           + PROD_W'(ll);
  endfunction

  // sin(c + f) = sin c * cos f + cos c * sin f, rounded half up
  assign total = {1'b0, prod[0]} + {1'b0, prod[1]} + HALF;
  assign mag   = total[RSH+FRAC_BITS:RSH];
  assign sval  = $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    sa1  <= COARSE_SIN[hi];
    ca1  <= COARSE_COS[hi];
    sb1  <= FINE_SIN[lo];
    cb1  <= FINE_COS[lo];
    neg1 <= arg.neg;

    pp_hh[0] <= sa1[TBL_W-1:SPLIT] * cb1[TBL_W-1:SPLIT];
    pp_hl[0] <= sa1[TBL_W-1:SPLIT] * cb1[SPLIT-1:0];
    pp_lh[0] <= sa1[SPLIT-1:0] * cb1[TBL_W-1:SPLIT];
    pp_ll[0] <= sa1[SPLIT-1:0] * cb1[SPLIT-1:0];
    pp_hh[1] <= ca1[TBL_W-1:SPLIT] * sb1[TBL_W-1:SPLIT];
    pp_hl[1] <= ca1[TBL_W-1:SPLIT] * sb1[SPLIT-1:0];
    pp_lh[1] <= ca1[SPLIT-1:0] * sb1[TBL_W-1:SPLIT];
    pp_ll[1] <= ca1[SPLIT-1:0] * sb1[SPLIT-1:0];
    neg2     <= neg1;

    prod[0] <= combine(pp_hh[0], pp_hl[0], pp_lh[0], pp_ll[0]);
    prod[1] <= combine(pp_hh[1], pp_hl[1], pp_lh[1], pp_ll[1]);
    neg3    <= neg2;

    val <= neg3 ? -sval : sval;
  end

endmodule

`default_nettype wire

### rtl/eam_back.sv
`default_nettype none

module eam_back import eam_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  item_t                   item,
  output logic                    done,
  output logic signed [OUT_W-1:0] right_x,
  output logic signed [OUT_W-1:0] right_y,
  output logic signed [OUT_W-1:0] right_z,
  output logic signed [OUT_W-1:0] up_x,
  output logic signed [OUT_W-1:0] up_y,
  output logic signed [OUT_W-1:0] up_z,
  output logic signed [OUT_W-1:0] fwd_x,
  output logic signed [OUT_W-1:0] fwd_y,
  output logic signed [OUT_W-1:0] fwd_z
);

  localparam int W      = FRAC_BITS + 2;
  localparam int PW     = 2 * W;
  localparam int SIN_LAT = 4;
  localparam logic signed [W:0] ONE = (W + 1)'(1) << FRAC_BITS;

  logic [SIN_LAT-1:0] vld_s;
  logic               vld_a, vld_b;

  logic signed [W-1:0] sp, cp, sh, ch, sb, cb;

  // stage A: two-factor products and first half of the triples
  logic signed [W-1:0] a_cbch, a_sbcp, a_cbsh, a_sbch, a_cbcp;
  logic signed [W-1:0] a_sbsh, a_shcp, a_chcp, a_spsb, a_spcb;
  logic signed [W-1:0] a_sh, a_ch, a_sp;
  // stage B: triples
  logic signed [W-1:0] b_spsbsh, b_spsbch, b_spcbsh, b_spcbch;
  logic signed [W-1:0] b_cbch, b_sbcp, b_cbsh, b_sbch, b_cbcp;
  logic signed [W-1:0] b_sbsh, b_shcp, b_chcp, b_sp;

  // (a*b) >>> FRAC_BITS, result fits back in W bits
  function automatic logic signed [W-1:0] qmul(logic signed [W-1:0] a,
                                               logic signed [W-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    return $signed(p[FRAC_BITS+W-1:FRAC_BITS]);
  endfunction

  function automatic logic signed [W:0] ext(logic signed [W-1:0] a);
    return $signed({a[W-1], a});
  endfunction

  // clamp to +/- one, then fit to the output field
  function automatic logic signed [OUT_W-1:0] clamp_out(logic signed [W:0] v);
    logic signed [W-1:0] c;
    if (v > ONE) begin
      c = ONE[W-1:0];
    end else if (v < -ONE) begin
      c = $signed(-ONE[W-1:0]);
    end else begin
      c = v[W-1:0];
    end
    return OUT_W'(c);
  endfunction

  eam_sine #(.FRAC_BITS(FRAC_BITS)) u_sp (.clk(clk), .arg(item.sp), .val(sp));
  eam_sine #(.FRAC_BITS(FRAC_BITS)) u_cp (.clk(clk), .arg(item.cp), .val(cp));
  eam_sine #(.FRAC_BITS(FRAC_BITS)) u_sh (.clk(clk), .arg(item.sh), .val(sh));
  eam_sine #(.FRAC_BITS(FRAC_BITS)) u_ch (.clk(clk), .arg(item.ch), .val(ch));
  eam_sine #(.FRAC_BITS(FRAC_BITS)) u_sb (.clk(clk), .arg(item.sb), .val(sb));
  eam_sine #(.FRAC_BITS(FRAC_BITS)) u_cb (.clk(clk), .arg(item.cb), .val(cb));

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s <= '0;
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld_s <= {vld_s[SIN_LAT-2:0], in_valid};
      vld_a <= vld_s[SIN_LAT-1];
      vld_b <= vld_a;
      done  <= vld_b;
    end
  end

  // products
  always_ff @(posedge clk) begin
    a_cbch <= qmul(cb, ch);
    a_sbcp <= qmul(sb, cp);
    a_cbsh <= qmul(cb, sh);
    a_sbch <= qmul(sb, ch);
    a_cbcp <= qmul(cb, cp);
    a_sbsh <= qmul(sb, sh);
    a_shcp <= qmul(sh, cp);
    a_chcp <= qmul(ch, cp);
    a_spsb <= qmul(sp, sb);
    a_spcb <= qmul(sp, cb);
    a_sh   <= sh;
    a_ch   <= ch;
    a_sp   <= sp;

    b_spsbsh <= qmul(a_spsb, a_sh);
    b_spsbch <= qmul(a_spsb, a_ch);
    b_spcbsh <= qmul(a_spcb, a_sh);
    b_spcbch <= qmul(a_spcb, a_ch);
    b_cbch   <= a_cbch;
    b_sbcp   <= a_sbcp;
    b_cbsh   <= a_cbsh;
    b_sbch   <= a_sbch;
    b_cbcp   <= a_cbcp;
    b_sbsh   <= a_sbsh;
    b_shcp   <= a_shcp;
    b_chcp   <= a_chcp;
    b_sp     <= a_sp;
  end

  // sums, clamp and result register
  always_ff @(posedge clk) begin
    right_x <= clamp_out(ext(b_cbch) + ext(b_spsbsh));
    right_y <= clamp_out(ext(b_sbcp));
    right_z <= clamp_out(ext(b_spsbch) - ext(b_cbsh));
    up_x    <= clamp_out(ext(b_spcbsh) - ext(b_sbch));
    up_y    <= clamp_out(ext(b_cbcp));
    up_z    <= clamp_out(ext(b_sbsh) + ext(b_spcbch));
    fwd_x   <= clamp_out(ext(b_shcp));
    fwd_y   <= clamp_out(-ext(b_sp));
    fwd_z   <= clamp_out(ext(b_chcp));
  end

endmodule

`default_nettype wire

### rtl/euler_angles_to_rotation_matrix.sv
// Rotation matrix from pitch, heading and bank binary angles
// (65536 units per turn). Each element is signed with FRAC_BITS
// fraction bits, clamped to +/- one, low 16 bits on the ports.
//
// Request channel: drive pitch, heading, bank and raise start; the
// request is taken at a rising edge where start is high and busy low.
// Result channel: done is high for exactly one cycle with all nine
// elements valid; the receiver has no way to hold a result.
//
// Path: an accepted request passes through the front register, queue,
// four sine stages, two product stages and the sum/clamp register
// before done rises. Throughput: one request per clock; the back
// end drains the four-entry queue every cycle, so busy stays low.
// Sine values come from coarse/fine tables combined by a pipelined
// angle-sum multiply in each of six sine units.
//
// Reset (rst, synchronous) empties the queue and clears all valid
// bits; no result is produced for requests in flight at reset.
`default_nettype none

module euler_angles_to_rotation_matrix import eam_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ANG_W-1:0]        pitch,
  input  logic [ANG_W-1:0]        heading,
  input  logic [ANG_W-1:0]        bank,
  output logic                    busy,
  output logic                    done,
  output logic signed [OUT_W-1:0] right_x,
  output logic signed [OUT_W-1:0] right_y,
  output logic signed [OUT_W-1:0] right_z,
  output logic signed [OUT_W-1:0] up_x,
  output logic signed [OUT_W-1:0] up_y,
  output logic signed [OUT_W-1:0] up_z,
  output logic signed [OUT_W-1:0] fwd_x,
  output logic signed [OUT_W-1:0] fwd_y,
  output logic signed [OUT_W-1:0] fwd_z
);

  logic  q_full;
  logic  push;
  logic  pop;
  item_t front_item;
  item_t back_item;

  eam_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .pitch   (pitch),
    .heading (heading),
    .bank    (bank),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .item    (front_item)
  );

  eam_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_item),
    .full    (q_full),
    .pop     (pop),
    .rd_data (back_item)
  );

  eam_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop),
    .item     (back_item),
    .done     (done),
    .right_x  (right_x),
    .right_y  (right_y),
    .right_z  (right_z),
    .up_x     (up_x),
    .up_y     (up_y),
    .up_z     (up_z),
    .fwd_x    (fwd_x),
    .fwd_y    (fwd_y),
    .fwd_z    (fwd_z)
  );

endmodule

`default_nettype wire

### bench/rotation_checker.sv
`timescale 1ns / 100ps

// Watches the request and result channels of the rotation block, predicts
// each matrix from the accepted angles and compares it element by element.
module rotation_checker import eam_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [ANG_W-1:0]        pitch,
  input  logic [ANG_W-1:0]        heading,
  input  logic [ANG_W-1:0]        bank,
  input  logic                    done,
  input  logic signed [OUT_W-1:0] right_x,
  input  logic signed [OUT_W-1:0] right_y,
  input  logic signed [OUT_W-1:0] right_z,
  input  logic signed [OUT_W-1:0] up_x,
  input  logic signed [OUT_W-1:0] up_y,
  input  logic signed [OUT_W-1:0] up_z,
  input  logic signed [OUT_W-1:0] fwd_x,
  input  logic signed [OUT_W-1:0] fwd_y,
  input  logic signed [OUT_W-1:0] fwd_z,
  output int                      mismatches,
  output int                      in_flight,
  output int                      matrices_checked
);

  localparam bit [63:0] PI_FIX62 = 64'hC90FDAA22168C235;
  localparam bit [63:0] PI_HI    = PI_FIX62 >> 32;
  localparam bit [63:0] PI_LO    = PI_FIX62 & 64'hFFFFFFFF;
  localparam int        QTR_TURN = 16384;
  localparam int        SHOW_MAX = 40;

  // Element slots inside a predicted matrix
  typedef enum int {
    RIGHT_X, RIGHT_Y, RIGHT_Z, UP_X, UP_Y, UP_Z, FWD_X, FWD_Y, FWD_Z
  } elem_e;

  typedef struct packed {
    logic [ANG_W-1:0]            p;
    logic [ANG_W-1:0]            h;
    logic [ANG_W-1:0]            b;
    logic [8:0][OUT_W-1:0]       m;
  } rotation_t;

  rotation_t expected_q[$];
  rotation_t want;

  // The 64 bits from bit 62 up of an unsigned Q62 product
  function automatic bit [63:0] q62_mul(bit [63:0] a, bit [63:0] b);
    bit [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Sine over the first quadrant by Taylor series, rounded half up
  function automatic longint quarter_sine(int unsigned r);
    bit [63:0] rr, x, x2, term, acc, divisor;
    rr   = r;
    x    = ((rr * PI_HI) << 17) + ((rr * PI_LO) >> 15);
    x2   = q62_mul(x, x);
    term = x;
    acc  = x;
    for (int n = 1; n <= 14; n++) begin
      divisor = 64'((2 * n) * (2 * n + 1));
      term    = q62_mul(term, x2) / divisor;
      if (n % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    acc = (acc + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    return longint'(acc);
  endfunction

  // Fold a binary angle into the first quadrant and apply the sign
  function automatic longint angle_sine(logic [ANG_W-1:0] a);
    int unsigned r;
    longint      mag;
    r = a[13:0];
    if (a[14]) r = QTR_TURN - r;
    mag = quarter_sine(r);
    return a[15] ? -mag : mag;
  endfunction

  function automatic longint fx_mul2(longint a, longint b);
    return (a * b) >>> FRAC_BITS;
  endfunction

  function automatic longint fx_mul3(longint a, longint b, longint c);
    return (((a * b) >>> FRAC_BITS) * c) >>> FRAC_BITS;
  endfunction

  function automatic logic [OUT_W-1:0] clamp_unit(longint v);
    longint one;
    one = longint'(1) << FRAC_BITS;
    if (v > one)  v = one;
    if (v < -one) v = -one;
    return OUT_W'(v);
  endfunction

  // Predicted rotation matrix for one set of angles
  function automatic rotation_t rotation_from_angles(logic [ANG_W-1:0] p,
                                                     logic [ANG_W-1:0] h,
                                                     logic [ANG_W-1:0] b);
    rotation_t rot;
    longint sp, cp, sh, ch, sb, cb;
    sp = angle_sine(p);
    cp = angle_sine(p + ANG_W'(QTR_TURN));
    sh = angle_sine(h);
    ch = angle_sine(h + ANG_W'(QTR_TURN));
    sb = angle_sine(b);
    cb = angle_sine(b + ANG_W'(QTR_TURN));
    rot.p = p;
    rot.h = h;
    rot.b = b;
    rot.m[RIGHT_X] = clamp_unit(fx_mul2(cb, ch) + fx_mul3(sp, sb, sh));
    rot.m[RIGHT_Y] = clamp_unit(fx_mul2(sb, cp));
    rot.m[RIGHT_Z] = clamp_unit(fx_mul3(sp, sb, ch) - fx_mul2(cb, sh));
    rot.m[UP_X]    = clamp_unit(fx_mul3(sp, cb, sh) - fx_mul2(sb, ch));
    rot.m[UP_Y]    = clamp_unit(fx_mul2(cb, cp));
    rot.m[UP_Z]    = clamp_unit(fx_mul2(sb, sh) + fx_mul3(sp, cb, ch));
    rot.m[FWD_X]   = clamp_unit(fx_mul2(sh, cp));
    rot.m[FWD_Y]   = clamp_unit(-sp);
    rot.m[FWD_Z]   = clamp_unit(fx_mul2(ch, cp));
    return rot;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOW_MAX)
      $display("MISMATCH @%0t: %s", $time, msg);
    else if (mismatches == SHOW_MAX + 1)
      $display("MISMATCH @%0t: further mismatches counted but not shown", $time);
  endtask

  task automatic check_elem(string label, logic [OUT_W-1:0] got,
                            logic [OUT_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0d expected %0d (pitch %0d heading %0d bank %0d)",
                                label, $signed(got), $signed(exp_val),
                                want.p, want.h, want.b));
  endtask

  initial begin
    mismatches       = 0;
    in_flight        = 0;
    matrices_checked = 0;
  end

  // Compare results first, then record the request taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      expected_q.delete();
    end else begin
      if (done) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          want = expected_q.pop_front();
          check_elem("right_x", right_x, want.m[RIGHT_X]);
          check_elem("right_y", right_y, want.m[RIGHT_Y]);
          check_elem("right_z", right_z, want.m[RIGHT_Z]);
          check_elem("up_x",    up_x,    want.m[UP_X]);
          check_elem("up_y",    up_y,    want.m[UP_Y]);
          check_elem("up_z",    up_z,    want.m[UP_Z]);
          check_elem("fwd_x",   fwd_x,   want.m[FWD_X]);
          check_elem("fwd_y",   fwd_y,   want.m[FWD_Y]);
          check_elem("fwd_z",   fwd_z,   want.m[FWD_Z]);
          matrices_checked++;
        end
      end
      if (start && !busy)
        expected_q.push_back(rotation_from_angles(pitch, heading, bank));
    end
    in_flight = expected_q.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

// Drives angle requests into the rotation block; the checker beside it
// predicts and compares the matrices.
module tb_top;
  import eam_pkg::*;

  localparam int FRAC_BITS  = 14;
  localparam int RANDOM_N   = 750;
  localparam int DIRECTED_N = 20;
  localparam int CYCLE_MAX  = 100000;
  localparam int SETTLE     = 20;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    start;
  logic [ANG_W-1:0]        pitch;
  logic [ANG_W-1:0]        heading;
  logic [ANG_W-1:0]        bank;
  logic                    busy;
  logic                    done;
  logic signed [OUT_W-1:0] right_x, right_y, right_z;
  logic signed [OUT_W-1:0] up_x, up_y, up_z;
  logic signed [OUT_W-1:0] fwd_x, fwd_y, fwd_z;

  int mismatches;
  int matrix_in_flight;
  int matrices_checked;
  int requests_sent = 0;
  int cycle_cnt     = 0;

  always #10 clk = ~clk;

  euler_angles_to_rotation_matrix #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst(rst), .start(start),
    .pitch(pitch), .heading(heading), .bank(bank),
    .busy(busy), .done(done),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z),
    .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z)
  );

  rotation_checker #(.FRAC_BITS(FRAC_BITS)) matrix_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pitch(pitch), .heading(heading), .bank(bank),
    .done(done),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z),
    .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
    .mismatches(mismatches),
    .in_flight(matrix_in_flight),
    .matrices_checked(matrices_checked)
  );

  // Hold one request until an edge with busy low takes it
  task automatic send_request(input logic [ANG_W-1:0] p, input logic [ANG_W-1:0] h,
                              input logic [ANG_W-1:0] b);
    logic taken;
    start   <= 1'b1;
    pitch   <= p;
    heading <= h;
    bank    <= b;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    requests_sent++;
  endtask

  // Gap cycles with junk on the angle ports
  task automatic idle_cycles(input int n);
    repeat (n) begin
      start   <= 1'b0;
      pitch   <= ANG_W'($urandom);
      heading <= ANG_W'($urandom);
      bank    <= ANG_W'($urandom);
      @(posedge clk);
    end
  endtask

  // Stop sending until every request has its matrix back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (matrix_in_flight != 0);
    @(posedge clk);
  endtask

  // Mix of uniform angles and angles near quadrant and octant edges
  function automatic logic [ANG_W-1:0] pick_angle();
    logic [ANG_W-1:0] base;
    case ($urandom_range(0, 3))
      1: begin
        base = ANG_W'($urandom_range(0, 3)) << 14;
        return base + ANG_W'($urandom_range(0, 8)) - ANG_W'(4);
      end
      2: begin
        base = ANG_W'($urandom_range(0, 7)) << 13;
        return base + ANG_W'($urandom_range(0, 64)) - ANG_W'(32);
      end
      default: return ANG_W'($urandom);
    endcase
  endfunction

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_MAX) begin
      $display("Timeout after %0d cycles", CYCLE_MAX);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    bit calm;
    rst     <= 1'b1;
    start   <= 1'b0;
    pitch   <= '0;
    heading <= '0;
    bank    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero, quarter turns, all-ones, quadrant edges, octants
    send_request(16'd0,     16'd0,     16'd0);
    send_request(16'd16384, 16'd0,     16'd0);
    send_request(16'd0,     16'd16384, 16'd0);
    send_request(16'd0,     16'd0,     16'd16384);
    send_request(16'd32768, 16'd32768, 16'd32768);
    send_request(16'd49152, 16'd49152, 16'd49152);
    send_request(16'hFFFF,  16'hFFFF,  16'hFFFF);
    send_request(16'd1,     16'd1,     16'd1);
    send_request(16'd16383, 16'd16385, 16'd32767);
    send_request(16'd32769, 16'd49151, 16'd49153);
    send_request(16'd8192,  16'd8192,  16'd8192);
    send_request(16'd57344, 16'd8192,  16'd24576);
    send_request(16'd8192,  16'd24576, 16'd40960);
    send_request(16'hAAAA,  16'h5555,  16'hFFFF);
    send_request(16'h5555,  16'hAAAA,  16'h0000);
    send_request(16'hFFFF,  16'h0000,  16'h8000);
    send_request(16'h4000,  16'h2000,  16'hE000);
    send_request(16'h1000,  16'hF000,  16'h7000);
    send_request(16'd24576, 16'd57344, 16'd8192);
    send_request(16'h7FFF,  16'h8001,  16'hC000);
    wait_drained();

    // Random requests; a calm stretch in the middle, one full drain later.
    // Outside the calm stretch each request has a 6% chance of an idle gap first.
    for (int i = 0; i < RANDOM_N; i++) begin
      calm = (i >= 300 && i < 450);
      if (i == 550)
        wait_drained();
      else if (!calm && $urandom_range(0, 99) < 6)
        idle_cycles($urandom_range(1, 4));
      send_request(pick_angle(), pick_angle(), pick_angle());
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d angle requests: %0d directed corner cases, the rest random",
             requests_sent, DIRECTED_N);
    $display("with quadrant-edge bias; %0d rotation matrices compared element by element.",
             matrices_checked);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
rtl/eam_pkg.sv
rtl/eam_front.sv
rtl/eam_fifo.sv
rtl/eam_sine.sv
rtl/eam_back.sv
rtl/euler_angles_to_rotation_matrix.sv
bench/rotation_checker.sv
bench/tb_top.sv
